// File: rtl/sbr_pkg.sv
// Shared constants and types for the shader binding relocator.
package sbr_pkg;

   // Mark store geometry
   localparam int MAX_IDS     = 4096;
   localparam int ID_WIDTH    = $clog2(MAX_IDS);
   localparam int EPOCH_WIDTH = 8;

   // Module format constants
   localparam logic [31:0] SPV_MAGIC    = 32'h0723_0203;
   localparam logic [2:0]  HEADER_WORDS = 3'd5;
   localparam logic [15:0] OP_VARIABLE  = 16'd59;
   localparam logic [15:0] OP_DECORATE  = 16'd71;
   localparam logic [31:0] SC_UNIFORM   = 32'd2;
   localparam logic [31:0] DEC_BINDING  = 32'd33;
   localparam logic [15:0] MIN_LENGTH   = 16'd4;

   // Request from the parser to the mark store
   typedef struct packed {
      logic                rd_en;     // look up a decoration target
      logic                wr_en;     // mark a uniform variable
      logic                new_pass;  // first word of a marking pass: clear marks
      logic [ID_WIDTH-1:0] id;
   } mark_req_type;

   // One result word
   typedef struct packed {
      logic [31:0] word_out;
      logic        last_out;
      logic        id_overflow;
   } rsp_word_type;

endpackage

// File: rtl/sbr_mark_store.sv
// Uniform-variable mark store: epoch-tagged memory with a clearing sweep.
module sbr_mark_store (
   input  logic                 clock,
   input  logic                 reset,
   input  sbr_pkg::mark_req_type mark_req,
   output logic                 busy,
   output logic                 mark_hit
);
   import sbr_pkg::*;

   localparam logic [1:0] ST_RUN   = 2'd0;
   localparam logic [1:0] ST_SWEEP = 2'd1;

   // An entry is marked when its tag equals the current epoch
   logic [EPOCH_WIDTH-1:0] tag_mem [MAX_IDS];
   logic [EPOCH_WIDTH-1:0] rd_tag_ff;
   logic [EPOCH_WIDTH-1:0] epoch_ff, epoch_in;
   logic [1:0]             state_ff, state_in;
   logic [ID_WIDTH-1:0]    sweep_cnt_ff, sweep_cnt_in;
   logic                   sweeping;
   logic                   mem_we;
   logic [ID_WIDTH-1:0]    mem_addr;
   logic [EPOCH_WIDTH-1:0] mem_wdata;

   assign sweeping = (state_ff == ST_SWEEP);
   assign busy     = sweeping;

   // Epoch advance per marking pass; a wrap forces a full sweep
   always_comb begin
      epoch_in     = epoch_ff;
      state_in     = state_ff;
      sweep_cnt_in = sweep_cnt_ff;
      case (state_ff)
         ST_RUN: begin
            if (mark_req.new_pass) begin
               if (epoch_ff == {EPOCH_WIDTH{1'b1}}) begin
                  epoch_in     = EPOCH_WIDTH'(1);
                  state_in     = ST_SWEEP;
                  sweep_cnt_in = '0;
               end else begin
                  epoch_in = epoch_ff + EPOCH_WIDTH'(1);
               end
            end
         end
         ST_SWEEP: begin
            sweep_cnt_in = sweep_cnt_ff + ID_WIDTH'(1);
            if (sweep_cnt_ff == ID_WIDTH'(MAX_IDS - 1)) begin
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff     <= EPOCH_WIDTH'(1);
         state_ff     <= ST_SWEEP;
         sweep_cnt_ff <= '0;
      end else begin
         epoch_ff     <= epoch_in;
         state_ff     <= state_in;
         sweep_cnt_ff <= sweep_cnt_in;
      end
   end

   // Single port: sweep owns it while running, input is stalled then
   assign mem_we    = sweeping || mark_req.wr_en;
   assign mem_addr  = sweeping ? sweep_cnt_ff : mark_req.id;
   assign mem_wdata = sweeping ? '0 : epoch_ff;

   // Lookups and marks come from different instructions, never the same word
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem[mem_addr] <= mem_wdata;
      end
      if (mark_req.rd_en) begin
         rd_tag_ff <= tag_mem[mem_addr];
      end
   end

   // Epoch is constant inside a module, so the held tag stays comparable
   assign mark_hit = (rd_tag_ff == epoch_ff);

endmodule

// File: rtl/sbr_parser.sv
// Instruction framing, uniform marking and binding patch for each word.
module sbr_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [31:0]           word_in,
   input  logic                  pass_select,
   input  logic                  last_word,
   input  logic [31:0]           binding_shift,
   input  logic                  mark_hit,
   output sbr_pkg::mark_req_type mark_req,
   output logic                  rsp_load,
   output sbr_pkg::rsp_word_type rsp_word
);
   import sbr_pkg::*;

   logic [2:0]          hdr_cnt_ff, hdr_cnt_in;
   logic                magic_ff, magic_in;
   logic                halted_ff, halted_in;
   logic [15:0]         len_ff, len_in;
   logic [15:0]         pos_ff, pos_in;
   logic                is_var_ff, is_var_in;
   logic                is_dec_ff, is_dec_in;
   logic [ID_WIDTH-1:0] tgt_id_ff, tgt_id_in;
   logic                tgt_oob_ff, tgt_oob_in;
   logic                bind_dec_ff, bind_dec_in;
   logic                ovf_ff, ovf_in;
   logic [31:0]         result;
   logic [15:0]         word_len;
   logic [15:0]         pos_next;
   logic                word_oob;

   assign word_len = word_in[31:16];
   assign pos_next = pos_ff + 16'd1;
   assign word_oob = (word_in >= 32'(MAX_IDS));

   // Per-word parse step
   always_comb begin
      hdr_cnt_in  = hdr_cnt_ff;
      magic_in    = magic_ff;
      halted_in   = halted_ff;
      len_in      = len_ff;
      pos_in      = pos_ff;
      is_var_in   = is_var_ff;
      is_dec_in   = is_dec_ff;
      tgt_id_in   = tgt_id_ff;
      tgt_oob_in  = tgt_oob_ff;
      bind_dec_in = bind_dec_ff;
      ovf_in      = ovf_ff;
      result      = word_in;
      mark_req    = '0;
      mark_req.id = tgt_id_ff;

      if (accept) begin
         mark_req.new_pass = (hdr_cnt_ff == 3'd0) && !pass_select;

         if (hdr_cnt_ff < HEADER_WORDS) begin
            // header words
            if (hdr_cnt_ff == 3'd0) begin
               magic_in = (word_in == SPV_MAGIC);
            end
            hdr_cnt_in = hdr_cnt_ff + 3'd1;
         end else if (magic_ff && !halted_ff) begin
            if (pos_ff == 16'd0) begin
               // instruction word: zero length halts parsing
               if (word_len == 16'd0) begin
                  halted_in = 1'b1;
               end else begin
                  is_var_in = (word_in[15:0] == OP_VARIABLE) && (word_len >= MIN_LENGTH);
                  is_dec_in = (word_in[15:0] == OP_DECORATE) && (word_len >= MIN_LENGTH);
                  len_in    = word_len;
                  pos_in    = (word_len == 16'd1) ? 16'd0 : 16'd1;
               end
            end else begin
               if (is_var_ff) begin
                  // result ID, then storage class
                  if (pos_ff == 16'd2) begin
                     tgt_id_in  = word_in[ID_WIDTH-1:0];
                     tgt_oob_in = word_oob;
                  end else if (pos_ff == 16'd3 && !pass_select && word_in == SC_UNIFORM) begin
                     if (tgt_oob_ff) begin
                        ovf_in = 1'b1;
                     end else begin
                        mark_req.wr_en = 1'b1;
                     end
                  end
               end else if (is_dec_ff) begin
                  // target (look up its mark now), decoration, then operand
                  if (pos_ff == 16'd1) begin
                     tgt_id_in      = word_in[ID_WIDTH-1:0];
                     tgt_oob_in     = word_oob;
                     mark_req.rd_en = 1'b1;
                     mark_req.id    = word_in[ID_WIDTH-1:0];
                  end else if (pos_ff == 16'd2) begin
                     bind_dec_in = (word_in == DEC_BINDING);
                  end else if (pos_ff == 16'd3 && pass_select && bind_dec_ff
                               && !tgt_oob_ff && mark_hit) begin
                     result = word_in + binding_shift;
                  end
               end
               pos_in = (pos_next >= len_ff) ? 16'd0 : pos_next;
            end
         end

         // end of module restarts framing
         if (last_word) begin
            hdr_cnt_in = 3'd0;
            magic_in   = 1'b0;
            halted_in  = 1'b0;
            pos_in     = 16'd0;
         end
      end
   end

   assign rsp_load             = accept && pass_select;
   assign rsp_word.word_out    = result;
   assign rsp_word.last_out    = last_word;
   assign rsp_word.id_overflow = ovf_in;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_cnt_ff <= 3'd0;
         magic_ff   <= 1'b0;
         halted_ff  <= 1'b0;
         pos_ff     <= 16'd0;
         ovf_ff     <= 1'b0;
      end else begin
         hdr_cnt_ff <= hdr_cnt_in;
         magic_ff   <= magic_in;
         halted_ff  <= halted_in;
         pos_ff     <= pos_in;
         ovf_ff     <= ovf_in;
      end
   end

   // Instruction payload, always written before use inside an instruction
   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      is_var_ff   <= is_var_in;
      is_dec_ff   <= is_dec_in;
      tgt_id_ff   <= tgt_id_in;
      tgt_oob_ff  <= tgt_oob_in;
      bind_dec_ff <= bind_dec_in;
   end

endmodule

// File: rtl/sbr_out_buffer.sv
// Output register with a skid stage for the result channel.
module sbr_out_buffer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  sbr_pkg::rsp_word_type load_word,
   output logic                  full,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sbr_pkg::rsp_word_type rsp_word
);
   import sbr_pkg::*;

   logic         out_vld_ff, out_vld_in;
   logic         skid_vld_ff, skid_vld_in;
   rsp_word_type out_ff, out_in;
   rsp_word_type skid_ff, skid_in;
   logic         take;

   assign take = out_vld_ff && !rsp_stall;

   // Load goes to the output register when it frees, else to the skid
   // (load never comes while the skid is full: input is stalled then)
   always_comb begin
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      out_in      = out_ff;
      skid_in     = skid_ff;
      if (load) begin
         if (!out_vld_ff || take) begin
            out_in     = load_word;
            out_vld_in = 1'b1;
         end else begin
            skid_in     = load_word;
            skid_vld_in = 1'b1;
         end
      end else if (take) begin
         if (skid_vld_ff) begin
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end else begin
            out_vld_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_vld_ff;
   assign rsp_valid = out_vld_ff;
   assign rsp_word  = out_ff;

endmodule

// File: rtl/shader_binding_relocator.sv
// Top level: relocates uniform buffer bindings in a streamed shader module.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_stall    req_word_in, req_pass_select, req_last_word
//   rsp      out  rsp_valid/rsp_stall    rsp_word_out, rsp_last_out, rsp_id_overflow
//   csr      in   csr_valid/csr_ready    csr_data (binding shift)
//
// One word per cycle unless req_stall; a patching-pass word is registered onto rsp.
// Marks live in one tag memory; the target lookup starts two words before the patch.
// After reset, a clearing sweep over every mark entry holds req_stall.
// Every 255th marking pass wraps the epoch tag and repeats that sweep.
// req_stall comes from registers: high during a sweep or while the output skid is full.
module shader_binding_relocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_word_in,
   input  logic        req_pass_select,
   input  logic        req_last_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_word_out,
   output logic        rsp_last_out,
   output logic        rsp_id_overflow,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);
   import sbr_pkg::*;

   logic [31:0]  shift_ff;
   logic         accept;
   logic         store_busy;
   logic         mark_hit;
   logic         skid_full;
   logic         rsp_load;
   mark_req_type mark_req;
   rsp_word_type load_word;
   rsp_word_type out_word;

   // Binding shift register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 32'd0;
      end else if (csr_valid && csr_ready) begin
         shift_ff <= csr_data;
      end
   end

   assign req_stall = store_busy || skid_full;
   assign accept    = req_valid && !req_stall;

   sbr_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .word_in       (req_word_in),
      .pass_select   (req_pass_select),
      .last_word     (req_last_word),
      .binding_shift (shift_ff),
      .mark_hit      (mark_hit),
      .mark_req      (mark_req),
      .rsp_load      (rsp_load),
      .rsp_word      (load_word)
   );

   sbr_mark_store u_mark_store (
      .clock    (clock),
      .reset    (reset),
      .mark_req (mark_req),
      .busy     (store_busy),
      .mark_hit (mark_hit)
   );

   sbr_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .load      (rsp_load),
      .load_word (load_word),
      .full      (skid_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (out_word)
   );

   assign rsp_word_out    = out_word.word_out;
   assign rsp_last_out    = out_word.last_out;
   assign rsp_id_overflow = out_word.id_overflow;

`ifndef SYNTHESIS
   // no mark access reaches the store during its clearing sweep
   a_no_access_in_sweep: assert property (@(posedge clock) disable iff (reset)
      store_busy |-> !(mark_req.rd_en || mark_req.wr_en))
      else $error("mark access during sweep");

   // a full skid stage always sits behind a valid output word
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_full |-> rsp_valid)
      else $error("skid full with empty output");

   // a patching word taken into an empty output shows next cycle
   a_patch_word_out: assert property (@(posedge clock) disable iff (reset)
      (accept && req_pass_select && !rsp_valid) |=> rsp_valid)
      else $error("patching word lost");

   // a marking word produces no result
   a_mark_word_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_pass_select && !rsp_valid) |=> !rsp_valid)
      else $error("marking word produced a result");
`endif

endmodule
